>>> hw/rtl/sliced_polygon_sample_coverage_unit_macros.svh
// Assertion macros for the checker of the coverage unit.
`ifndef SLICED_POLYGON_SAMPLE_COVERAGE_UNIT_MACROS_SVH
`define SLICED_POLYGON_SAMPLE_COVERAGE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/spsc_pkg.sv
`timescale 1ns / 1ps

package spsc_pkg;

   // Storage geometry.
   localparam int SLICES          = 16;
   localparam int EDGES_PER_SLICE = 64;
   localparam int GRID_MAX        = 5;
   localparam int SLICE_W         = 4;
   localparam int EDGE_AW         = 6;
   localparam int STORE_DEPTH     = SLICES * EDGES_PER_SLICE;
   localparam int STORE_AW        = SLICE_W + EDGE_AW;

   // Shared divider sizes.
   localparam int DIV_NUM_W = 38;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [1:0] {
      CMD_WRITE_EDGE = 2'd0,
      CMD_SET_COUNT  = 2'd1,
      CMD_QUERY      = 2'd2,
      CMD_NONE       = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      CSR_MIN_Y         = 2'd0,
      CSR_MAX_Y         = 2'd1,
      CSR_SLICES_IN_USE = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW_START,
      ST_ROW_DIV,
      ST_SLICE_START,
      ST_SLICE_DIV,
      ST_COL_START,
      ST_COL_DIV,
      ST_EDGE_NEXT,
      ST_EDGE_LOAD,
      ST_EDGE_MUL,
      ST_EDGE_CMP,
      ST_SAMPLE_END,
      ST_COV_START,
      ST_COV_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic signed [31:0] x2;
      logic signed [31:0] y2;
   } edge_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [3:0]         slice;
      logic [6:0]         edge_slot;
      logic signed [31:0] coord_a_x;
      logic signed [31:0] coord_a_y;
      logic signed [31:0] coord_b_x;
      logic signed [31:0] coord_b_y;
      logic [2:0]         grid_size;
   } req_type;

   typedef struct packed {
      logic [4:0]  hits;
      logic [4:0]  samples;
      logic [16:0] coverage;
   } rsp_type;

   typedef struct packed {
      logic ready;
      logic store_we;
      logic div_start;
      logic rsp_load;
   } ctrl_type;

endpackage

>>> hw/rtl/spsc_ram.sv
`timescale 1ns / 1ps

module spsc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sliced_polygon_sample_coverage_unit.sv
`timescale 1ns / 1ps
// Write-edge, set-count and unused commands are handled in the idle state as they are accepted.
// A query's duration grows with the grid size G and the edge count n in the chosen slice;
// the shared 38-step divider and the per-edge multiply sequence set it.
// One request is in work at a time; a finished result waits in an output register.
// Synchronous reset clears the control state and slice edge counts and presets the
// configuration registers; edge store contents stay undefined until written.
module sliced_polygon_sample_coverage_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spsc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spsc_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_write_data
);

   spsc_pkg::state_type state_ff, state_in;
   spsc_pkg::ctrl_type  ctrl;

   // Configuration registers.
   logic signed [31:0] min_y_ff, max_y_ff;
   logic [4:0]         slices_ff;
   logic [6:0]         count_ff [spsc_pkg::SLICES];

   // Query registers.
   logic signed [31:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [2:0]         grid_ff, row_ff, col_ff;
   logic signed [32:0] py_ff, px_ff;
   logic [3:0]         slice_ff;
   logic [6:0]         nedges_ff, eidx_ff;
   logic               parity_ff;
   logic [4:0]         hits_ff;
   logic               off_neg_ff;

   // Shared divider.
   logic [spsc_pkg::DIV_NUM_W-1:0] div_num_ff, div_num_in;
   logic [spsc_pkg::DIV_DEN_W-1:0] div_rem_ff, div_den_ff, div_den_in;
   logic [spsc_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic                           off_neg_in;

   // Edge test.
   logic        dx_neg_ff, dpx_neg_ff;
   logic [33:0] mag_a0_ff, mag_a1_ff, mag_b0_ff, mag_b1_ff;
   logic [2:0]  mcnt_ff;
   logic [50:0] mul_ff;
   logic [67:0] acc0_ff, acc1_ff;

   logic              rsp_valid_ff;
   spsc_pkg::rsp_type rsp_ff;

   logic             accept;
   logic [2:0]       g_clamped;
   logic [4:0]       s_eff;
   logic [3:0]       s_m1;
   logic [2:0]       gm1;
   logic [4:0]       samples_w;

   assign accept = req_valid && ctrl.ready;
   assign gm1    = grid_ff - 3'd1;
   assign samples_w = 5'(6'(grid_ff) * 6'(grid_ff));

   // Grid size and slice count clamps.
   always_comb begin
      priority if (req_payload.grid_size == 3'd0) begin
         g_clamped = 3'd1;
      end else if (req_payload.grid_size > 3'(spsc_pkg::GRID_MAX)) begin
         g_clamped = 3'(spsc_pkg::GRID_MAX);
      end else begin
         g_clamped = req_payload.grid_size;
      end
      priority if (slices_ff == 5'd0) begin
         s_eff = 5'd1;
      end else if (slices_ff > 5'(spsc_pkg::SLICES)) begin
         s_eff = 5'(spsc_pkg::SLICES);
      end else begin
         s_eff = slices_ff;
      end
   end
   assign s_m1 = 4'(s_eff - 5'd1);

   // Grid offset numerator: size * (2k - (G-1)).
   logic [2:0]         off_idx;
   logic signed [31:0] off_size;
   logic signed [4:0]  off_k;
   logic signed [36:0] off_num;
   logic [33:0]        off_mag;
   logic [34:0]        off_abs;
   logic signed [34:0] off_val;
   logic signed [32:0] off_coord;

   always_comb begin
      if (state_ff == spsc_pkg::ST_ROW_START || state_ff == spsc_pkg::ST_ROW_DIV) begin
         off_idx   = row_ff;
         off_size  = by_ff;
         off_coord = 33'(ay_ff);
      end else begin
         off_idx   = col_ff;
         off_size  = bx_ff;
         off_coord = 33'(ax_ff);
      end
   end
   assign off_k   = $signed({1'b0, off_idx, 1'b0}) - $signed({2'b00, gm1});
   assign off_num = 37'(off_size) * 37'(off_k);
   assign off_mag = off_num[36] ? 34'(-off_num) : off_num[33:0];
   // Floor division: round the magnitude away from zero for negative numerators.
   assign off_abs = 35'(div_num_ff[33:0]) + 35'(off_neg_ff && (|div_rem_ff));
   assign off_val = off_neg_ff ? -$signed(off_abs) : $signed(off_abs);

   // Slice selection from the row's y.
   logic signed [33:0] sl_d;
   logic signed [32:0] sl_span;
   logic               sl_trivial;
   logic [37:0]        sl_num;
   logic [3:0]         sl_pick;

   assign sl_d       = 34'(py_ff) - 34'(min_y_ff);
   assign sl_span    = 33'(max_y_ff) - 33'(min_y_ff);
   assign sl_trivial = (s_eff == 5'd1) || (sl_span <= 0) || (sl_d <= 0);
   assign sl_num     = {5'b0, sl_d[32:0]} * {34'b0, s_m1};
   assign sl_pick    = (div_num_ff > 38'(s_m1)) ? s_m1 : div_num_ff[3:0];

   // Divider operand selection.
   always_comb begin
      div_num_in = 38'(off_mag);
      div_den_in = 33'({gm1, 1'b0});
      off_neg_in = off_num[36];
      unique case (state_ff)
         spsc_pkg::ST_SLICE_START: begin
            div_num_in = sl_num;
            div_den_in = sl_span;
            off_neg_in = 1'b0;
         end
         spsc_pkg::ST_COV_START: begin
            div_num_in = 38'({hits_ff, 16'b0}) + 38'(samples_w[4:1]);
            div_den_in = 33'(samples_w);
            off_neg_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   logic [33:0] div_shift;
   logic        div_ge;
   logic        div_done;
   assign div_shift = {div_rem_ff, div_num_ff[spsc_pkg::DIV_NUM_W-1]};
   assign div_ge    = div_shift >= {1'b0, div_den_ff};
   assign div_done  = div_cnt_ff == '0;

   // Edge store.
   spsc_pkg::edge_type                  wr_edge, rd_edge;
   logic [spsc_pkg::STORE_AW-1:0]       wr_addr, rd_addr;
   logic [$bits(spsc_pkg::edge_type)-1:0] rd_bits;

   assign wr_edge = '{x1: req_payload.coord_a_x, y1: req_payload.coord_a_y,
                      x2: req_payload.coord_b_x, y2: req_payload.coord_b_y};
   assign wr_addr = {req_payload.slice, req_payload.edge_slot[spsc_pkg::EDGE_AW-1:0]};
   assign rd_addr = {slice_ff, eidx_ff[spsc_pkg::EDGE_AW-1:0]};
   assign rd_edge = spsc_pkg::edge_type'(rd_bits);

   spsc_ram #(
      .WIDTH($bits(spsc_pkg::edge_type)),
      .DEPTH(spsc_pkg::STORE_DEPTH)
   ) u_edge_store (
      .clock  (clock),
      .wr_en  (ctrl.store_we),
      .wr_addr(wr_addr),
      .wr_data(wr_edge),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   // Edge orientation and qualification.
   logic               e_swap, e_count;
   logic signed [31:0] lx1, ly1, lx2, ly2;
   logic signed [32:0] e_dx, e_dy;
   logic signed [33:0] e_ddy, e_dpx;

   assign e_swap  = rd_edge.y1 > rd_edge.y2;
   assign lx1     = e_swap ? rd_edge.x2 : rd_edge.x1;
   assign ly1     = e_swap ? rd_edge.y2 : rd_edge.y1;
   assign lx2     = e_swap ? rd_edge.x1 : rd_edge.x2;
   assign ly2     = e_swap ? rd_edge.y1 : rd_edge.y2;
   assign e_count = (rd_edge.y1 != rd_edge.y2) && (py_ff > 33'(ly1)) && (py_ff < 33'(ly2));
   assign e_dx    = 33'(lx2) - 33'(lx1);
   assign e_dy    = 33'(ly2) - 33'(ly1);
   assign e_ddy   = 34'(py_ff) - 34'(ly1);
   assign e_dpx   = 34'(px_ff) - 34'(lx1);

   // Partial-product multiplier: 34 by 17 bits per step.
   logic [33:0] mul_a, mul_b;
   logic [16:0] mul_bh;
   logic [1:0]  acc_step;
   logic [67:0] acc_add;
   logic signed [68:0] cmp_lhs, cmp_rhs;

   assign mul_a    = mcnt_ff[1] ? mag_a1_ff : mag_a0_ff;
   assign mul_b    = mcnt_ff[1] ? mag_b1_ff : mag_b0_ff;
   assign mul_bh   = mcnt_ff[0] ? mul_b[33:17] : mul_b[16:0];
   assign acc_step = 2'(mcnt_ff - 3'd1);
   assign acc_add  = acc_step[0] ? {mul_ff, 17'b0} : {17'b0, mul_ff};
   assign cmp_lhs  = dx_neg_ff ? -$signed({1'b0, acc0_ff}) : $signed({1'b0, acc0_ff});
   assign cmp_rhs  = dpx_neg_ff ? -$signed({1'b0, acc1_ff}) : $signed({1'b0, acc1_ff});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spsc_pkg::ST_IDLE: begin
            if (accept && req_payload.command == spsc_pkg::CMD_QUERY) begin
               state_in = spsc_pkg::ST_ROW_START;
            end
         end
         spsc_pkg::ST_ROW_START: begin
            state_in = (grid_ff == 3'd1) ? spsc_pkg::ST_SLICE_START : spsc_pkg::ST_ROW_DIV;
         end
         spsc_pkg::ST_ROW_DIV: begin
            if (div_done) begin
               state_in = spsc_pkg::ST_SLICE_START;
            end
         end
         spsc_pkg::ST_SLICE_START: begin
            state_in = sl_trivial ? spsc_pkg::ST_COL_START : spsc_pkg::ST_SLICE_DIV;
         end
         spsc_pkg::ST_SLICE_DIV: begin
            if (div_done) begin
               state_in = spsc_pkg::ST_COL_START;
            end
         end
         spsc_pkg::ST_COL_START: begin
            state_in = (grid_ff == 3'd1) ? spsc_pkg::ST_EDGE_NEXT : spsc_pkg::ST_COL_DIV;
         end
         spsc_pkg::ST_COL_DIV: begin
            if (div_done) begin
               state_in = spsc_pkg::ST_EDGE_NEXT;
            end
         end
         spsc_pkg::ST_EDGE_NEXT: begin
            state_in = (eidx_ff == nedges_ff) ? spsc_pkg::ST_SAMPLE_END
                                              : spsc_pkg::ST_EDGE_LOAD;
         end
         spsc_pkg::ST_EDGE_LOAD: begin
            state_in = e_count ? spsc_pkg::ST_EDGE_MUL : spsc_pkg::ST_EDGE_NEXT;
         end
         spsc_pkg::ST_EDGE_MUL: begin
            if (mcnt_ff == 3'd4) begin
               state_in = spsc_pkg::ST_EDGE_CMP;
            end
         end
         spsc_pkg::ST_EDGE_CMP: begin
            state_in = spsc_pkg::ST_EDGE_NEXT;
         end
         spsc_pkg::ST_SAMPLE_END: begin
            priority if (col_ff != gm1) begin
               state_in = spsc_pkg::ST_COL_START;
            end else if (row_ff != gm1) begin
               state_in = spsc_pkg::ST_ROW_START;
            end else begin
               state_in = spsc_pkg::ST_COV_START;
            end
         end
         spsc_pkg::ST_COV_START: begin
            state_in = spsc_pkg::ST_COV_DIV;
         end
         spsc_pkg::ST_COV_DIV: begin
            if (div_done) begin
               state_in = spsc_pkg::ST_FINISH;
            end
         end
         spsc_pkg::ST_FINISH: begin
            if (ctrl.rsp_load) begin
               state_in = spsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spsc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control outputs.
   always_comb begin
      ctrl.ready     = state_ff == spsc_pkg::ST_IDLE;
      ctrl.store_we  = (state_ff == spsc_pkg::ST_IDLE) && req_valid
                       && req_payload.command == spsc_pkg::CMD_WRITE_EDGE
                       && req_payload.edge_slot < 7'(spsc_pkg::EDGES_PER_SLICE);
      ctrl.div_start = ((state_ff == spsc_pkg::ST_ROW_START ||
                         state_ff == spsc_pkg::ST_COL_START) && grid_ff != 3'd1)
                       || (state_ff == spsc_pkg::ST_SLICE_START && !sl_trivial)
                       || state_ff == spsc_pkg::ST_COV_START;
      ctrl.rsp_load  = (state_ff == spsc_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spsc_pkg::ST_IDLE;
         min_y_ff     <= 32'sd0;
         max_y_ff     <= 32'sd65536;
         slices_ff    <= 5'd1;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
         for (int i = 0; i < spsc_pkg::SLICES; i++) begin
            count_ff[i] <= 7'd0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (spsc_pkg::csr_index_type'(csr_index))
               spsc_pkg::CSR_MIN_Y:         min_y_ff  <= csr_write_data;
               spsc_pkg::CSR_MAX_Y:         max_y_ff  <= csr_write_data;
               spsc_pkg::CSR_SLICES_IN_USE: slices_ff <= csr_write_data[4:0];
               default: begin
               end
            endcase
         end
         if (accept && req_payload.command == spsc_pkg::CMD_SET_COUNT) begin
            count_ff[req_payload.slice] <=
               (req_payload.edge_slot > 7'(spsc_pkg::EDGES_PER_SLICE))
               ? 7'(spsc_pkg::EDGES_PER_SLICE) : req_payload.edge_slot;
         end
         priority if (ctrl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         priority if (ctrl.div_start) begin
            div_cnt_ff <= 6'(spsc_pkg::DIV_NUM_W);
         end else if (!div_done) begin
            div_cnt_ff <= div_cnt_ff - 6'd1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      // Shared restoring divider, one quotient bit per cycle.
      priority if (ctrl.div_start) begin
         div_num_ff <= div_num_in;
         div_den_ff <= div_den_in;
         div_rem_ff <= '0;
         off_neg_ff <= off_neg_in;
      end else if (!div_done) begin
         div_rem_ff <= div_ge ? 33'(div_shift - {1'b0, div_den_ff}) : div_shift[32:0];
         div_num_ff <= {div_num_ff[spsc_pkg::DIV_NUM_W-2:0], div_ge};
      end

      unique case (state_ff)
         spsc_pkg::ST_IDLE: begin
            if (accept) begin
               ax_ff   <= req_payload.coord_a_x;
               ay_ff   <= req_payload.coord_a_y;
               bx_ff   <= req_payload.coord_b_x;
               by_ff   <= req_payload.coord_b_y;
               grid_ff <= g_clamped;
               row_ff  <= 3'd0;
               col_ff  <= 3'd0;
               hits_ff <= 5'd0;
            end
         end
         spsc_pkg::ST_ROW_START: begin
            if (grid_ff == 3'd1) begin
               py_ff <= off_coord;
            end
         end
         spsc_pkg::ST_ROW_DIV: begin
            if (div_done) begin
               py_ff <= off_coord + 33'(off_val);
            end
         end
         spsc_pkg::ST_SLICE_START: begin
            if (sl_trivial) begin
               slice_ff <= 4'd0;
            end
         end
         spsc_pkg::ST_SLICE_DIV: begin
            if (div_done) begin
               slice_ff <= sl_pick;
            end
         end
         spsc_pkg::ST_COL_START: begin
            nedges_ff <= count_ff[slice_ff];
            eidx_ff   <= 7'd0;
            parity_ff <= 1'b0;
            if (grid_ff == 3'd1) begin
               px_ff <= off_coord;
            end
         end
         spsc_pkg::ST_COL_DIV: begin
            if (div_done) begin
               px_ff <= off_coord + 33'(off_val);
            end
         end
         spsc_pkg::ST_EDGE_LOAD: begin
            // Crossing x lies right of the sample when dx*(py-y1) > (px-x1)*dy.
            dx_neg_ff  <= e_dx[32];
            dpx_neg_ff <= e_dpx[33];
            mag_a0_ff  <= e_dx[32] ? 34'(-e_dx) : 34'(e_dx);
            mag_a1_ff  <= e_dpx[33] ? 34'(-e_dpx) : e_dpx;
            mag_b0_ff  <= e_ddy;
            mag_b1_ff  <= 34'(e_dy);
            mcnt_ff    <= 3'd0;
            acc0_ff    <= '0;
            acc1_ff    <= '0;
            if (!e_count) begin
               eidx_ff <= eidx_ff + 7'd1;
            end
         end
         spsc_pkg::ST_EDGE_MUL: begin
            mcnt_ff <= mcnt_ff + 3'd1;
            if (mcnt_ff != 3'd4) begin
               mul_ff <= {17'b0, mul_a} * {34'b0, mul_bh};
            end
            if (mcnt_ff != 3'd0) begin
               if (acc_step[1]) begin
                  acc1_ff <= acc1_ff + acc_add;
               end else begin
                  acc0_ff <= acc0_ff + acc_add;
               end
            end
         end
         spsc_pkg::ST_EDGE_CMP: begin
            parity_ff <= parity_ff ^ (cmp_lhs > cmp_rhs);
            eidx_ff   <= eidx_ff + 7'd1;
         end
         spsc_pkg::ST_SAMPLE_END: begin
            hits_ff <= hits_ff + 5'(parity_ff);
            if (col_ff != gm1) begin
               col_ff <= col_ff + 3'd1;
            end else begin
               col_ff <= 3'd0;
               row_ff <= row_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase

      if (ctrl.rsp_load) begin
         rsp_ff.hits     <= hits_ff;
         rsp_ff.samples  <= samples_w;
         rsp_ff.coverage <= div_num_ff[16:0];
      end
   end

   assign req_stall   = !ctrl.ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hw/rtl/spsc_checker.sv
`timescale 1ns / 1ps
`include "sliced_polygon_sample_coverage_unit_macros.svh"

module spsc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input spsc_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input spsc_pkg::rsp_type rsp_payload
);

   logic rsp_waiting;
   logic samples_square;
   logic full_hits;
   logic query_taken;

   assign rsp_waiting    = rsp_valid && rsp_stall;
   assign samples_square = rsp_payload.samples == 5'd1 || rsp_payload.samples == 5'd4
                           || rsp_payload.samples == 5'd9 || rsp_payload.samples == 5'd16
                           || rsp_payload.samples == 5'd25;
   assign full_hits      = rsp_valid && rsp_payload.hits == rsp_payload.samples;
   assign query_taken    = req_valid && !req_stall
                           && req_payload.command == spsc_pkg::CMD_QUERY;

   // A stalled result stays put.
   `SPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting,
                     rsp_valid && $stable(rsp_payload), "stalled result changed")

   // The sample count is always a square of a legal grid size.
   `SPSC_ASSERT_SAME(a_samples_square, clock, reset, rsp_valid, samples_square,
                     "sample count is not a square")

   // Hits never exceed the samples tested.
   `SPSC_ASSERT_SAME(a_hits_bound, clock, reset, rsp_valid,
                     rsp_payload.hits <= rsp_payload.samples, "hit count above sample count")

   // Full hit count reports full coverage.
   `SPSC_ASSERT_SAME(a_full_cover, clock, reset, full_hits,
                     rsp_payload.coverage == 17'd65536, "full hits without full coverage")

   // A query request keeps the block busy on the following cycle.
   `SPSC_ASSERT_NEXT(a_query_busy, clock, reset, query_taken, req_stall,
                     "request taken during a query")

endmodule

bind sliced_polygon_sample_coverage_unit spsc_checker u_spsc_checker (.*);

>>> dv/tb_sliced_polygon_sample_coverage_unit.sv
`timescale 1ns / 1ps

import spsc_pkg::*;

// Tracks the polygon store and the region registers, and predicts coverage results.
class coverage_scoreboard;
   edge_type      edges[STORE_DEPTH];
   bit            written[STORE_DEPTH];
   int            written_prefix[SLICES];
   int            edge_counts[SLICES];
   longint        region_min_y;
   longint        region_max_y;
   int            slices_cfg;
   rsp_type       coverage_q[$];
   int            errors;

   function new();
      foreach (written[k]) written[k] = 0;
      foreach (edge_counts[k]) begin
         edge_counts[k] = 0;
         written_prefix[k] = 0;
      end
      region_min_y = 0;
      region_max_y = 65536;
      slices_cfg = 1;
      errors = 0;
   endfunction

   function void write_csr(csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_MIN_Y:         region_min_y = longint'($signed(data));
         CSR_MAX_Y:         region_max_y = longint'($signed(data));
         CSR_SLICES_IN_USE: slices_cfg = int'(data[4:0]);
         default: ;
      endcase
   endfunction

   function int active_slices();
      if (slices_cfg == 0) return 1;
      if (slices_cfg > SLICES) return SLICES;
      return slices_cfg;
   endfunction

   function longint grid_offset(longint size, longint k, longint g);
      longint num;
      longint den;
      longint q;
      if (g <= 1) return 0;
      num = size * (2 * k - (g - 1));
      den = 2 * (g - 1);
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function int choose_slice(longint py);
      int     s;
      longint span;
      longint d;
      longint idx;
      s = active_slices();
      span = region_max_y - region_min_y;
      d = py - region_min_y;
      if (s == 1 || span <= 0 || d <= 0) return 0;
      idx = (d * longint'(s - 1)) / span;
      if (idx > s - 1) idx = s - 1;
      return int'(idx);
   endfunction

   // Even-odd crossing test against the edges of the sample's slice.
   function bit point_inside(longint px, longint py);
      int                  sl;
      bit                  parity;
      edge_type            e;
      longint              x1, y1, x2, y2, t;
      logic signed [127:0] wa, wb, wc, wd;
      sl = choose_slice(py);
      parity = 0;
      for (int i = 0; i < edge_counts[sl]; i++) begin
         e = edges[sl * EDGES_PER_SLICE + i];
         x1 = longint'(e.x1);
         y1 = longint'(e.y1);
         x2 = longint'(e.x2);
         y2 = longint'(e.y2);
         if (y1 != y2) begin
            if (y1 > y2) begin
               t = x1; x1 = x2; x2 = t;
               t = y1; y1 = y2; y2 = t;
            end
            if (py > y1 && py < y2) begin
               wa = x2 - x1;
               wb = py - y1;
               wc = px - x1;
               wd = y2 - y1;
               if (wa * wb > wc * wd) parity = ~parity;
            end
         end
      end
      return parity;
   endfunction

   // Applies one accepted request and queues the coverage result it causes.
   function void note_request(req_type r);
      int      base;
      longint  g;
      longint  py;
      longint  px;
      int      hits;
      rsp_type exp_rsp;
      case (r.command)
         CMD_WRITE_EDGE: begin
            if (r.edge_slot < EDGES_PER_SLICE) begin
               base = r.slice * EDGES_PER_SLICE;
               edges[base + r.edge_slot] = '{x1: r.coord_a_x, y1: r.coord_a_y,
                                             x2: r.coord_b_x, y2: r.coord_b_y};
               written[base + r.edge_slot] = 1;
               while (written_prefix[r.slice] < EDGES_PER_SLICE &&
                      written[base + written_prefix[r.slice]])
                  written_prefix[r.slice]++;
            end
         end
         CMD_SET_COUNT: begin
            edge_counts[r.slice] = (r.edge_slot > EDGES_PER_SLICE) ? EDGES_PER_SLICE
                                                                   : int'(r.edge_slot);
         end
         CMD_QUERY: begin
            g = r.grid_size;
            if (g < 1) g = 1;
            if (g > GRID_MAX) g = GRID_MAX;
            hits = 0;
            for (longint i = 0; i < g; i++) begin
               py = longint'(r.coord_a_y) + grid_offset(longint'(r.coord_b_y), i, g);
               for (longint j = 0; j < g; j++) begin
                  px = longint'(r.coord_a_x) + grid_offset(longint'(r.coord_b_x), j, g);
                  if (point_inside(px, py)) hits++;
               end
            end
            exp_rsp.hits = hits[4:0];
            exp_rsp.samples = 5'(g * g);
            exp_rsp.coverage = 17'((longint'(hits) * 65536 + (g * g) / 2) / (g * g));
            coverage_q = {coverage_q, exp_rsp};
         end
         default: ;
      endcase
   endfunction

   function void check_response(rsp_type got);
      rsp_type exp_rsp;
      if (coverage_q.size() == 0) begin
         $error("unexpected coverage result: hits %0d samples %0d coverage %0d",
                got.hits, got.samples, got.coverage);
         errors++;
         return;
      end
      exp_rsp = coverage_q.pop_front();
      if (got.hits !== exp_rsp.hits) begin
         $error("hits mismatch: expected %0d actual %0d", exp_rsp.hits, got.hits);
         errors++;
      end
      if (got.samples !== exp_rsp.samples) begin
         $error("samples mismatch: expected %0d actual %0d", exp_rsp.samples, got.samples);
         errors++;
      end
      if (got.coverage !== exp_rsp.coverage) begin
         $error("coverage mismatch: expected %0d actual %0d",
                exp_rsp.coverage, got.coverage);
         errors++;
      end
   endfunction
endclass

module tb_sliced_polygon_sample_coverage_unit;
   localparam int     ONE          = 65536;
   localparam int     HALF         = 32768;
   localparam int     QUARTER      = 16384;
   localparam longint CYCLE_LIMIT  = 20000000;
   localparam int     SETTLE       = 40;
   localparam int     LONG_HOLD    = 3000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_write_enable;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;

   coverage_scoreboard scoreboard;
   longint cycle_count;
   bit     quiet_phase;
   bit     hold_request;

   sliced_polygon_sample_coverage_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a 4 ns period; it starts low so the first rising edge comes after setup.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Check every accepted coverage result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) scoreboard.check_response(rsp_payload);
   end

   // Mostly short gaps, a few long ones.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int n;
      rsp_stall = 1'b0;
      hold_request = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            n = gap_length();
            rsp_stall = (n != 0);
            repeat (n == 0 ? 1 : n) @(negedge clock);
         end
      end
   end

   function automatic logic [31:0] near_coord();
      return 32'($urandom_range(0, 10 * ONE) - 5 * ONE);
   endfunction

   function automatic logic [31:0] any_coord();
      if ($urandom_range(0, 99) < 85) return near_coord();
      return $urandom;
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_stall);
      scoreboard.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_edge(int sl, int slot, logic [31:0] ax, logic [31:0] ay,
                            logic [31:0] bx, logic [31:0] by);
      req_type r;
      r = '{command: CMD_WRITE_EDGE, slice: 4'(sl), edge_slot: 7'(slot),
            coord_a_x: ax, coord_a_y: ay, coord_b_x: bx, coord_b_y: by,
            grid_size: 3'($urandom)};
      send_request(r);
   endtask

   task automatic send_count(int sl, int count);
      req_type r;
      r = '{command: CMD_SET_COUNT, slice: 4'(sl), edge_slot: 7'(count),
            coord_a_x: $urandom, coord_a_y: $urandom, coord_b_x: $urandom,
            coord_b_y: $urandom, grid_size: 3'($urandom)};
      send_request(r);
   endtask

   task automatic send_query(logic [31:0] cx, logic [31:0] cy, logic [31:0] w,
                             logic [31:0] h, int g);
      req_type r;
      r = '{command: CMD_QUERY, slice: 4'($urandom), edge_slot: 7'($urandom),
            coord_a_x: cx, coord_a_y: cy, coord_b_x: w, coord_b_y: h,
            grid_size: 3'(g)};
      send_request(r);
   endtask

   // Drop valid and wait until every expected result is back and the block is idle.
   task automatic drain();
      req_valid = 1'b0;
      while (scoreboard.coverage_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_registers(logic [31:0] lo, logic [31:0] hi, logic [31:0] count);
      csr_write_enable = 1'b1;
      csr_index = CSR_MIN_Y;
      csr_write_data = lo;
      scoreboard.write_csr(CSR_MIN_Y, lo);
      @(negedge clock);
      csr_index = CSR_MAX_Y;
      csr_write_data = hi;
      scoreboard.write_csr(CSR_MAX_Y, hi);
      @(negedge clock);
      csr_index = CSR_SLICES_IN_USE;
      csr_write_data = count;
      scoreboard.write_csr(CSR_SLICES_IN_USE, count);
      @(negedge clock);
      csr_index = CSR_UNUSED;
      csr_write_data = $urandom;
      scoreboard.write_csr(CSR_UNUSED, csr_write_data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // One random request: mostly edge writes that extend a slice and queries.
   task automatic random_request();
      int r;
      int sl;
      int slot;
      int prefix;
      int g;
      logic [31:0] ay;
      r = $urandom_range(0, 99);
      sl = ($urandom_range(0, 99) < 30) ? $urandom_range(0, SLICES - 1)
                                        : $urandom_range(0, scoreboard.active_slices() - 1);
      prefix = scoreboard.written_prefix[sl];
      if (r < 40) begin
         r = $urandom_range(0, 99);
         if (r < 70 && prefix < EDGES_PER_SLICE) slot = prefix;
         else if (r < 90) slot = $urandom_range(0, EDGES_PER_SLICE - 1);
         else slot = $urandom_range(EDGES_PER_SLICE, 127);
         ay = any_coord();
         send_edge(sl, slot, any_coord(), ay, any_coord(),
                   ($urandom_range(0, 99) < 15) ? ay : any_coord());
      end else if (r < 55) begin
         if (prefix == EDGES_PER_SLICE) send_count(sl, $urandom_range(0, 127));
         else send_count(sl, $urandom_range(0, prefix));
      end else if (r < 95) begin
         g = ($urandom_range(0, 99) < 85) ? $urandom_range(1, GRID_MAX)
                                          : $urandom_range(0, 7);
         if ($urandom_range(0, 99) < 85)
            send_query(near_coord(), near_coord(), 32'($urandom_range(0, 4 * ONE) - 2 * ONE),
                       32'($urandom_range(0, 4 * ONE) - 2 * ONE), g);
         else
            send_query($urandom, $urandom, $urandom, $urandom, g);
      end else begin
         req_payload_noop();
      end
   endtask

   task automatic req_payload_noop();
      req_type r;
      r = '{command: CMD_NONE, slice: 4'($urandom), edge_slot: 7'($urandom),
            coord_a_x: $urandom, coord_a_y: $urandom, coord_b_x: $urandom,
            coord_b_y: $urandom, grid_size: 3'($urandom)};
      send_request(r);
   endtask

   initial begin
      int sl;
      scoreboard = new();
      cycle_count = 0;
      quiet_phase = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_MIN_Y;
      csr_write_data = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed: a square in slice 0 under the reset region.
      send_edge(0, 0, QUARTER, QUARTER, 3 * QUARTER, QUARTER);
      send_edge(0, 1, 3 * QUARTER, QUARTER, 3 * QUARTER, 3 * QUARTER);
      send_edge(0, 2, 3 * QUARTER, 3 * QUARTER, QUARTER, 3 * QUARTER);
      send_edge(0, 3, QUARTER, 3 * QUARTER, QUARTER, QUARTER);
      send_edge(0, EDGES_PER_SLICE, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000);
      send_count(0, 4);
      send_query(HALF, HALF, ONE, ONE, GRID_MAX);
      send_query(HALF, HALF, ONE, ONE, 1);
      send_query(HALF, HALF, ONE, ONE, 0);
      send_query(HALF, HALF, ONE, ONE, 7);
      send_query(HALF, HALF, HALF, HALF, 2);
      // Sample exactly on a vertical edge and exactly at a vertex height.
      send_query(QUARTER, HALF, 0, 0, 1);
      send_query(HALF, QUARTER, 0, 0, 1);
      send_query(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, GRID_MAX);
      send_query(HALF, HALF, -ONE, -HALF, 3);
      req_payload_noop();
      send_count(0, 0);
      send_query(HALF, HALF, ONE, ONE, 2);
      send_count(0, 4);
      send_query(3 * QUARTER, HALF, HALF, HALF, 3);
      drain();

      // Random phases over several region settings.
      for (int phase = 0; phase < 8; phase++) begin
         quiet_phase = (phase == 3);
         case (phase)
            0: write_registers(-4 * ONE, 4 * ONE, 4);
            1: write_registers(32'h8000_0000, 32'h7fff_ffff, 16);
            2: write_registers(4 * ONE, -4 * ONE, 8);
            3: write_registers(-5 * ONE, 5 * ONE, 32'hffff_ffe0);
            4: write_registers(-2 * ONE, 3 * ONE, 32'h0000_001f | ($urandom << 5));
            5: write_registers(0, 0, 1);
            default: write_registers(near_coord(), near_coord(), $urandom_range(0, 31));
         endcase
         if (phase == 2) hold_request = 1'b1;
         if (phase == 6) begin
            // Fill one slice completely and saturate its count.
            sl = $urandom_range(0, SLICES - 1);
            for (int k = 0; k < EDGES_PER_SLICE; k++)
               send_edge(sl, k, near_coord(), near_coord(), near_coord(), near_coord());
            send_count(sl, $urandom_range(EDGES_PER_SLICE, 127));
            for (int k = 0; k < 3; k++)
               send_query(near_coord(), near_coord(), ONE, ONE, GRID_MAX);
         end else begin
            for (int k = 0; k < 40; k++) random_request();
         end
         drain();
      end

      while (scoreboard.coverage_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.coverage_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
